// ===== rtl/gcl_pkg.sv =====
`default_nettype none

package gcl_pkg;

	localparam int FIRST_YEAR    = 1900;
	localparam int ROM_YEARS     = 201;
	localparam int ERA_DAYS      = 146097;
	localparam int ANCHOR_OFFSET = 719468 - 25537;
	localparam int MONTHS        = 12;

	localparam int DAYS_W = 17;
	localparam int IDX_W  = 8;
	localparam int WORD_W = 17;

	// day count rebase for the two 400-year eras that the table spans
	localparam logic signed [18:0] ERA4_SHIFT = 19'(4 * ERA_DAYS - ANCHOR_OFFSET);
	localparam logic signed [18:0] ERA5_SHIFT = 19'(5 * ERA_DAYS - ANCHOR_OFFSET);

	typedef struct packed {
		logic              ok;
		logic [DAYS_W-1:0] days;
	} gcl_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} gcl_fifo_stat_t;

	localparam logic [WORD_W-1:0] YEAR_ROM [0:ROM_YEARS-1] = '{
		17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554, 17'h056a0,
		17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255, 17'h0b540,
		17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50,
		17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0,
		17'h0ea50, 17'h06e95, 17'h05ad0, 17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
		17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2,
		17'h0a950, 17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
		17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4,
		17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0, 17'h096d0, 17'h04dd5,
		17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558, 17'h0b540, 17'h0b6a0, 17'h195a6,
		17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46,
		17'h0ab60, 17'h09570, 17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58,
		17'h05ac0, 17'h0ab60, 17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50,
		17'h07552, 17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
		17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
		17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4e0, 17'h0d260,
		17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0, 17'h04afb, 17'h04ad0, 17'h0a4d0,
		17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0,
		17'h0a577, 17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370,
		17'h049f8, 17'h04970, 17'h064b0, 17'h168a6, 17'h0ea50, 17'h06b20, 17'h1a6c4, 17'h0aae0,
		17'h0a2e0, 17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
		17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6, 17'h0ad50,
		17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930, 17'h07337, 17'h06aa0,
		17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4, 17'h0d160, 17'h0e968, 17'h0d520,
		17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0, 17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252,
		17'h0d520
	};

	function automatic logic [WORD_W-1:0] gcl_year_word(input logic [IDX_W-1:0] idx);
		logic [WORD_W-1:0] w;
		w = '0;
		if (int'(idx) < ROM_YEARS) begin
			w = YEAR_ROM[idx];
		end
		return w;
	endfunction

	// 29 * 12 plus one day per long month, plus the leap month if any
	function automatic logic [8:0] gcl_year_len(input logic [WORD_W-1:0] w);
		logic [8:0] total;
		total = 9'd348;
		for (int i = 4; i < 16; i++) begin
			total = total + 9'(w[i]);
		end
		if (w[3:0] != 4'd0) begin
			total = total + (w[16] ? 9'd30 : 9'd29);
		end
		return total;
	endfunction

	// day of a March-based year at which each Gregorian month starts
	function automatic logic [8:0] gcl_month_base(input logic [3:0] month);
		logic [8:0] b;
		case (month)
			4'd3:    b = 9'd0;
			4'd4:    b = 9'd31;
			4'd5:    b = 9'd61;
			4'd6:    b = 9'd92;
			4'd7:    b = 9'd122;
			4'd8:    b = 9'd153;
			4'd9:    b = 9'd184;
			4'd10:   b = 9'd214;
			4'd11:   b = 9'd245;
			4'd12:   b = 9'd275;
			4'd1:    b = 9'd306;
			4'd2:    b = 9'd337;
			default: b = 9'd0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gcl_front.sv =====
`default_nettype none

module gcl_front import gcl_pkg::*; #(
	parameter int TABLE_YEARS = 201
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire logic [13:0]    greg_year,
	input  wire logic [3:0]     greg_month,
	input  wire logic [4:0]     greg_day,
	input  wire gcl_fifo_stat_t stat,
	output logic                push,
	output gcl_item_t           push_data
);

	localparam logic [13:0] FIRST_Y = 14'(FIRST_YEAR);
	localparam logic [13:0] LAST_Y  = 14'(FIRST_YEAR + TABLE_YEARS - 1);

	logic        v_s1;
	logic        ok_s1;
	logic        era5_s1;
	logic [8:0]  yoe_s1;
	logic [8:0]  doy_s1;
	logic [1:0]  cent_s1;

	logic        accept;
	logic        ok_d;
	logic        jan_feb;
	logic [13:0] y_d;
	logic [13:0] yy_d;
	logic        era5_d;
	logic [13:0] yoe_d;
	logic [1:0]  cent_d;
	logic [8:0]  doy_d;

	logic [17:0]        doe;
	logic signed [18:0] rem;

	assign busy   = v_s1;
	assign accept = start && !v_s1;

	always_comb begin
		ok_d = (greg_year >= FIRST_Y) && (greg_year <= LAST_Y) &&
		       (greg_month >= 4'd1) && (greg_month <= 4'd12) && (greg_day != 5'd0);
		jan_feb = greg_month <= 4'd2;
		y_d     = greg_year - 14'(jan_feb);
		yy_d    = y_d - 14'd1600;
		era5_d  = yy_d >= 14'd400;
		yoe_d   = era5_d ? yy_d - 14'd400 : yy_d;
		cent_d  = 2'(yoe_d >= 14'd100) + 2'(yoe_d >= 14'd200) + 2'(yoe_d >= 14'd300);
		doy_d   = gcl_month_base(greg_month) + 9'(greg_day) - 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1   <= ok_d;
			era5_s1 <= era5_d;
			yoe_s1  <= yoe_d[8:0];
			cent_s1 <= cent_d;
			doy_s1  <= doy_d;
		end
	end

	always_comb begin
		doe = 18'(yoe_s1) * 18'd365 + 18'(yoe_s1[8:2]) + 18'(doy_s1) - 18'(cent_s1);
		rem = $signed({1'b0, doe}) + (era5_s1 ? ERA5_SHIFT : ERA4_SHIFT);
	end

	assign push           = v_s1 && !stat.full;
	assign push_data.ok   = ok_s1 && !rem[18];
	assign push_data.days = rem[DAYS_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/gcl_fifo.sv =====
`default_nettype none

module gcl_fifo import gcl_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire gcl_item_t push_data,
	input  wire logic      pop,
	output gcl_item_t      pop_data,
	output gcl_fifo_stat_t stat
);

	gcl_item_t  mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	assign pop_data   = mem_q[rptr_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;

endmodule

`default_nettype wire

// ===== rtl/gcl_back.sv =====
`default_nettype none

module gcl_back import gcl_pkg::*; #(
	parameter int TABLE_YEARS = 201
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gcl_fifo_stat_t stat,
	input  wire gcl_item_t      pop_data,
	output logic                pop,
	output logic                done,
	output logic                valid_res,
	output logic [11:0]         lunar_yr,
	output logic [3:0]          lunar_month,
	output logic [4:0]          lunar_day,
	output logic                is_leap_month
);

	localparam logic [IDX_W-1:0] END_IDX = IDX_W'(TABLE_YEARS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH
	} state_t;

	state_t             state_q;
	logic [DAYS_W-1:0]  rem_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WORD_W-1:0]  word_q;
	logic [3:0]         m_q;
	logic               in_leap_q;
	logic               done_q;
	logic               valid_q;
	logic [11:0]        year_q;
	logic [3:0]         month_q;
	logic [4:0]         day_q;
	logic               leap_q;

	logic [WORD_W-1:0]  word_rom;
	logic [8:0]         span;
	logic [4:0]         cur_len;

	always_comb begin
		word_rom = gcl_year_word(idx_q);
		span     = gcl_year_len(word_rom);
		if (in_leap_q) begin
			cur_len = word_q[16] ? 5'd30 : 5'd29;
		end else begin
			cur_len = word_q[5'(5'd16 - 5'(m_q))] ? 5'd30 : 5'd29;
		end
	end

	assign pop = (state_q == ST_IDLE) && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						rem_q <= pop_data.days;
						idx_q <= '0;
						if (pop_data.ok) begin
							state_q <= ST_YEAR;
						end else begin
							done_q  <= 1'b1;
							valid_q <= 1'b0;
							year_q  <= '0;
							month_q <= '0;
							day_q   <= '0;
							leap_q  <= 1'b0;
						end
					end
				end
				ST_YEAR: begin
					if (idx_q == END_IDX) begin
						// ran past the last table year
						done_q  <= 1'b1;
						valid_q <= 1'b0;
						year_q  <= '0;
						month_q <= '0;
						day_q   <= '0;
						leap_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (rem_q < DAYS_W'(span)) begin
						word_q    <= word_rom;
						m_q       <= 4'd1;
						in_leap_q <= 1'b0;
						state_q   <= ST_MONTH;
					end else begin
						rem_q <= rem_q - DAYS_W'(span);
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_MONTH: begin
					if (rem_q < DAYS_W'(cur_len)) begin
						done_q  <= 1'b1;
						valid_q <= 1'b1;
						year_q  <= 12'(FIRST_YEAR) + 12'(idx_q);
						month_q <= m_q;
						day_q   <= rem_q[4:0] + 5'd1;
						leap_q  <= in_leap_q;
						state_q <= ST_IDLE;
					end else begin
						rem_q <= rem_q - DAYS_W'(cur_len);
						// leap month follows the month it repeats
						if (!in_leap_q && m_q == word_q[3:0]) begin
							in_leap_q <= 1'b1;
						end else if (m_q == 4'(MONTHS)) begin
							done_q  <= 1'b1;
							valid_q <= 1'b0;
							year_q  <= '0;
							month_q <= '0;
							day_q   <= '0;
							leap_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							m_q       <= m_q + 4'd1;
							in_leap_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign valid_res     = valid_q;
	assign lunar_yr      = year_q;
	assign lunar_month   = month_q;
	assign lunar_day     = day_q;
	assign is_leap_month = leap_q;

endmodule

`default_nettype wire

// ===== rtl/gregorian_to_chinese_lunar_date.sv =====
// Channel   Handshake              Payload
// in        start / busy           greg_year, greg_month, greg_day
// out       done (one-cycle pulse) valid_res, lunar_yr, lunar_month, lunar_day,
//                                  is_leap_month
//
// Front registers a beat when start is high and busy low, works out the day count in
// the next cycle and drops it in a two-entry queue; busy stays up while that is blocked.
// Back walks one table year per cycle, then one month per cycle. Dates rejected up front
// skip the walk and have their done registered at the pop; running past the table ends
// the walk with an invalid result.
// Async reset clears control only; no clearing pass. Results cannot be stalled.
`default_nettype none

module gregorian_to_chinese_lunar_date import gcl_pkg::*; #(
	parameter int TABLE_YEARS = 201
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [13:0] greg_year,
	input  wire logic [3:0]  greg_month,
	input  wire logic [4:0]  greg_day,
	output logic             done,
	output logic             valid_res,
	output logic [11:0]      lunar_yr,
	output logic [3:0]       lunar_month,
	output logic [4:0]       lunar_day,
	output logic             is_leap_month
);

	gcl_fifo_stat_t stat;
	gcl_item_t      push_data;
	gcl_item_t      pop_data;
	logic           push;
	logic           pop;

	gcl_front #(
		.TABLE_YEARS(TABLE_YEARS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.greg_year (greg_year),
		.greg_month(greg_month),
		.greg_day  (greg_day),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	gcl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (stat)
	);

	gcl_back #(
		.TABLE_YEARS(TABLE_YEARS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.pop_data     (pop_data),
		.pop          (pop),
		.done         (done),
		.valid_res    (valid_res),
		.lunar_yr     (lunar_yr),
		.lunar_month  (lunar_month),
		.lunar_day    (lunar_day),
		.is_leap_month(is_leap_month)
	);

`ifndef NO_ASSERTIONS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !valid_res |-> lunar_yr == 12'd0 && lunar_month == 4'd0 &&
			lunar_day == 5'd0 && !is_leap_month)
		else $error("invalid result with nonzero fields");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && valid_res |-> lunar_month >= 4'd1 && lunar_month <= 4'd12 &&
			lunar_day >= 5'd1 && lunar_day <= 5'd30)
		else $error("lunar month or day out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front did not hold accepted beat");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !stat.empty)
		else $error("queue lost a pushed beat");
`endif

endmodule

`default_nettype wire
